FILE: rtl/core/efe_pkg.sv
// shared types and constants for the escaped frame encoder
`timescale 1ns / 1ps

package efe_pkg;

    // most words one input word can produce: start, two escaped length bytes,
    // one escaped payload byte and the checksum
    localparam int MaxResults = 8;
    localparam int CntW       = $clog2(MaxResults + 1);
    localparam int PosW       = $clog2(MaxResults);

    localparam logic [7:0]  EscXor      = 8'h20;
    localparam logic [7:0]  SumBase     = 8'hFF;
    localparam logic [16:0] HeaderWorst = 17'd5;

    // register reset values
    localparam logic [7:0]  StartReset  = 8'd126;
    localparam logic [7:0]  EscapeReset = 8'd125;
    localparam logic [15:0] MaxLenReset = 16'd256;

    // register map, byte address = 4 * index
    localparam int AddrW = 4;
    typedef enum logic [1:0] {
        REG_START  = 2'd0,
        REG_ESCAPE = 2'd1,
        REG_MAXLEN = 2'd2,
        REG_NONE   = 2'd3
    } reg_index_t;

    // current configuration as seen by the encoder
    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  escape_byte;
        logic [15:0] max_raw_length;
    } cfg_t;

    // all output words made from one input word
    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [CntW-1:0]            count;
        logic                       ends;
        logic                       ovf;
    } word_list_t;

endpackage

FILE: rtl/core/efe_cfg.sv
// configuration register file behind the APB-style port
`timescale 1ns / 1ps

module efe_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [efe_pkg::AddrW-1:0]  paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output efe_pkg::cfg_t              cfg
);

    efe_pkg::cfg_t      cfg_reg;
    efe_pkg::reg_index_t index;
    logic               wr_en;

    assign index  = efe_pkg::reg_index_t'(paddr[efe_pkg::AddrW-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte     <= efe_pkg::StartReset;
            cfg_reg.escape_byte    <= efe_pkg::EscapeReset;
            cfg_reg.max_raw_length <= efe_pkg::MaxLenReset;
        end
        else if (wr_en)
        begin
            case (index)
                efe_pkg::REG_START:  cfg_reg.start_byte     <= pwdata[7:0];
                efe_pkg::REG_ESCAPE: cfg_reg.escape_byte    <= pwdata[7:0];
                efe_pkg::REG_MAXLEN: cfg_reg.max_raw_length <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (index)
            efe_pkg::REG_START:  prdata = {24'd0, cfg_reg.start_byte};
            efe_pkg::REG_ESCAPE: prdata = {24'd0, cfg_reg.escape_byte};
            efe_pkg::REG_MAXLEN: prdata = {16'd0, cfg_reg.max_raw_length};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/core/efe_encode.sv
// input register, packet state and single-pass frame encoding
`timescale 1ns / 1ps

module efe_encode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  efe_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           payload_byte,
    input  logic                 first_of_packet,
    input  logic                 last_of_packet,
    input  logic [15:0]          frame_length,
    input  logic                 list_free,
    output logic                 list_load,
    output efe_pkg::word_list_t  list
);

    // input register
    logic        iv_reg;
    logic        iv_next;
    logic [7:0]  ib_reg;
    logic        ifirst_reg;
    logic        ilast_reg;
    logic [15:0] ilen_reg;

    // packet state
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [16:0] rc_reg;
    logic [16:0] rc_next;
    logic        disc_reg;
    logic        disc_next;
    logic        inpk_reg;
    logic        inpk_next;
    logic        zl_reg;
    logic        zl_next;

    logic        accept;
    logic [16:0] max_ext;

    logic [efe_pkg::MaxResults-1:0][7:0] bytes_v;
    logic [efe_pkg::CntW-1:0]            n;
    logic                                go;
    logic                                abort;
    logic                                ends_v;
    logic                                hi_esc;
    logic                                lo_esc;
    logic                                b_esc;

    assign list_load = iv_reg && list_free;
    assign in_stall  = iv_reg && !list_free;
    assign accept    = in_valid && !in_stall;
    assign max_ext   = {1'b0, cfg.max_raw_length};

    assign hi_esc = (ilen_reg[15:8] == cfg.start_byte) || (ilen_reg[15:8] == cfg.escape_byte);
    assign lo_esc = (ilen_reg[7:0] == cfg.start_byte) || (ilen_reg[7:0] == cfg.escape_byte);
    assign b_esc  = (ib_reg == cfg.start_byte) || (ib_reg == cfg.escape_byte);

    // input valid flag
    always_comb
    begin
        iv_next = iv_reg;
        if (accept)
        begin
            iv_next = 1'b1;
        end
        else if (list_load)
        begin
            iv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else
        begin
            iv_reg <= iv_next;
        end
    end

    // input payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ib_reg     <= payload_byte;
            ifirst_reg <= first_of_packet;
            ilast_reg  <= last_of_packet;
            ilen_reg   <= frame_length;
        end
    end

    // build the word list for the registered input word
    always_comb
    begin
        bytes_v   = '0;
        n         = '0;
        go        = 1'b1;
        abort     = 1'b0;
        ends_v    = 1'b0;
        sum_next  = sum_reg;
        rc_next   = rc_reg;
        disc_next = disc_reg;
        inpk_next = inpk_reg;
        zl_next   = zl_reg;

        // header or packet gating
        if (ifirst_reg)
        begin
            inpk_next = 1'b1;
            disc_next = 1'b0;
            sum_next  = '0;
            rc_next   = '0;
            zl_next   = (ilen_reg == 16'd0);
            if (17'({1'b0, ilen_reg} + efe_pkg::HeaderWorst) > max_ext)
            begin
                abort = 1'b1;
                go    = 1'b0;
            end
            else
            begin
                bytes_v[n[efe_pkg::PosW-1:0]] = cfg.start_byte;
                n       = n + 1'b1;
                rc_next = 17'd1;
                if (hi_esc)
                begin
                    bytes_v[n[efe_pkg::PosW-1:0]] = cfg.escape_byte;
                    n = n + 1'b1;
                    bytes_v[n[efe_pkg::PosW-1:0]] = ilen_reg[15:8] ^ efe_pkg::EscXor;
                    n       = n + 1'b1;
                    rc_next = 17'(rc_next + 17'd2);
                end
                else
                begin
                    bytes_v[n[efe_pkg::PosW-1:0]] = ilen_reg[15:8];
                    n       = n + 1'b1;
                    rc_next = 17'(rc_next + 17'd1);
                end
                if (lo_esc)
                begin
                    bytes_v[n[efe_pkg::PosW-1:0]] = cfg.escape_byte;
                    n = n + 1'b1;
                    bytes_v[n[efe_pkg::PosW-1:0]] = ilen_reg[7:0] ^ efe_pkg::EscXor;
                    n       = n + 1'b1;
                    rc_next = 17'(rc_next + 17'd2);
                end
                else
                begin
                    bytes_v[n[efe_pkg::PosW-1:0]] = ilen_reg[7:0];
                    n       = n + 1'b1;
                    rc_next = 17'(rc_next + 17'd1);
                end
            end
        end
        else if (!inpk_reg || disc_reg)
        begin
            go = 1'b0;
            if (ilast_reg)
            begin
                inpk_next = 1'b0;
                disc_next = 1'b0;
            end
        end

        // payload byte with limit checks
        if (go && !zl_next)
        begin
            if ((rc_next > max_ext) || (b_esc && (17'(rc_next + 17'd1) > max_ext)))
            begin
                abort = 1'b1;
                go    = 1'b0;
            end
            else
            begin
                sum_next = sum_next + ib_reg;
                if (b_esc)
                begin
                    bytes_v[n[efe_pkg::PosW-1:0]] = cfg.escape_byte;
                    n = n + 1'b1;
                    bytes_v[n[efe_pkg::PosW-1:0]] = ib_reg ^ efe_pkg::EscXor;
                    n       = n + 1'b1;
                    rc_next = 17'(rc_next + 17'd2);
                end
                else
                begin
                    bytes_v[n[efe_pkg::PosW-1:0]] = ib_reg;
                    n       = n + 1'b1;
                    rc_next = 17'(rc_next + 17'd1);
                end
            end
        end

        // checksum on the last word
        if (go && ilast_reg)
        begin
            if (rc_next > max_ext)
            begin
                abort = 1'b1;
            end
            else
            begin
                bytes_v[n[efe_pkg::PosW-1:0]] = efe_pkg::SumBase - sum_next;
                n         = n + 1'b1;
                ends_v    = 1'b1;
                inpk_next = 1'b0;
            end
        end

        // overflow word closes the list
        if (abort)
        begin
            bytes_v[n[efe_pkg::PosW-1:0]] = 8'd0;
            n      = n + 1'b1;
            ends_v = 1'b1;
            if (ilast_reg)
            begin
                inpk_next = 1'b0;
                disc_next = 1'b0;
            end
            else
            begin
                disc_next = 1'b1;
            end
        end

        list.bytes = bytes_v;
        list.count = n;
        list.ends  = ends_v;
        list.ovf   = abort;
    end

    // packet state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            rc_reg   <= '0;
            disc_reg <= 1'b0;
            inpk_reg <= 1'b0;
            zl_reg   <= 1'b0;
        end
        else if (list_load)
        begin
            sum_reg  <= sum_next;
            rc_reg   <= rc_next;
            disc_reg <= disc_next;
            inpk_reg <= inpk_next;
            zl_reg   <= zl_next;
        end
    end

endmodule

FILE: rtl/core/efe_outq.sv
// result register that hands out the word list one word per cycle while out_stall is low
`timescale 1ns / 1ps

module efe_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 list_load,
    input  efe_pkg::word_list_t  list,
    output logic                 list_free,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           frame_byte,
    output logic                 frame_end,
    output logic                 overflow
);

    logic [efe_pkg::MaxResults-1:0][7:0] bytes_reg;
    logic [efe_pkg::CntW-1:0]            cnt_reg;
    logic [efe_pkg::CntW-1:0]            cnt_next;
    logic                                end_reg;
    logic                                ovf_reg;
    logic                                pop;
    logic                                final_word;

    assign out_valid  = (cnt_reg != '0);
    assign pop        = out_valid && !out_stall;
    assign final_word = (cnt_reg == efe_pkg::CntW'(1));
    assign list_free  = !out_valid || (pop && final_word);

    assign frame_byte = bytes_reg[0];
    assign frame_end  = final_word && end_reg;
    assign overflow   = final_word && ovf_reg;

    // word count
    always_comb
    begin
        cnt_next = cnt_reg;
        if (list_load)
        begin
            cnt_next = list.count;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // word storage, shifts down as words leave
    always_ff @(posedge clk)
    begin
        if (list_load)
        begin
            bytes_reg <= list.bytes;
            end_reg   <= list.ends;
            ovf_reg   <= list.ovf;
        end
        else if (pop)
        begin
            bytes_reg <= {8'd0, bytes_reg[efe_pkg::MaxResults-1:1]};
        end
    end

endmodule

FILE: rtl/core/escaped_frame_encoder.sv
// Escaped frame encoder, top level.
// Input channel (in_valid/in_stall) takes one payload word per packet item with
// first_of_packet, last_of_packet and frame_length. Output channel
// (out_valid/out_stall) gives one raw frame byte per word with frame_end and
// overflow flags. The first item of a packet also produces the start byte and
// the escaped 16-bit length; the last item adds the checksum.
// Path: an accepted word is held in the input register, encoded from there
// and loaded into the output word register, which gives its first output word.
// Throughput: one input word produces 0 to 8 output words, and the output
// register sends one word per cycle while out_stall is low; a new list loads
// as the last word of the current one leaves. The output register is the
// pacing element.
// Stall: while out_stall is high the output word holds; one word waits in
// the input register, then in_stall rises.
// Reset: clears packet state and both valid flags and loads the register
// defaults (start 0x7E, escape 0x7D, limit 256). The user must write registers
// over the APB-style port only while the block is idle; it is not enforced.
`timescale 1ns / 1ps

module escaped_frame_encoder (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [efe_pkg::AddrW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                payload_byte,
    input  logic                      first_of_packet,
    input  logic                      last_of_packet,
    input  logic [15:0]               frame_length,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                frame_byte,
    output logic                      frame_end,
    output logic                      overflow
);

    efe_pkg::cfg_t       cfg;
    efe_pkg::word_list_t list;
    logic                list_load;
    logic                list_free;

    // configuration registers
    efe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // encoding stage
    efe_encode u_encode (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .payload_byte    (payload_byte),
        .first_of_packet (first_of_packet),
        .last_of_packet  (last_of_packet),
        .frame_length    (frame_length),
        .list_free       (list_free),
        .list_load       (list_load),
        .list            (list)
    );

    // output word register
    efe_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .list_load  (list_load),
        .list       (list),
        .list_free  (list_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_end  (frame_end),
        .overflow   (overflow)
    );

endmodule

FILE: tb/sv/efe_tb_pkg.sv
// frame predictor and output word scoreboard for the escaped frame encoder testbench
`timescale 1ns / 1ps

package efe_tb_pkg;

    localparam logic [7:0]  StuffXor      = 8'h20;
    localparam logic [7:0]  SumComplement = 8'hFF;
    localparam logic [16:0] FrameOverhead = 17'd5;

    // one raw byte of the encoded frame with its flags
    typedef struct packed {
        logic [7:0] data;
        logic       ends;
        logic       ovf;
    } frame_word_t;

    class frame_checker;

        // register copies
        logic [7:0]  start_val;
        logic [7:0]  escape_val;
        logic [15:0] max_len;

        // packet state
        logic [7:0]  sum;
        logic [16:0] raw_cnt;
        bit          dropping;
        bit          pkt_open;
        bit          empty_frame;

        frame_word_t frame_bytes[$];

        int errors;
        int words_seen;
        int frames_closed;
        int frames_aborted;

        function new();
            start_val      = 8'd126;
            escape_val     = 8'd125;
            max_len        = 16'd256;
            sum            = 8'd0;
            raw_cnt        = 17'd0;
            dropping       = 1'b0;
            pkt_open       = 1'b0;
            empty_frame    = 1'b0;
            errors         = 0;
            words_seen     = 0;
            frames_closed  = 0;
            frames_aborted = 0;
        endfunction

        function void set_reg(efe_pkg::reg_index_t idx, logic [31:0] value);
            case (idx)
                efe_pkg::REG_START:  start_val  = value[7:0];
                efe_pkg::REG_ESCAPE: escape_val = value[7:0];
                efe_pkg::REG_MAXLEN: max_len    = value[15:0];
                default: ;
            endcase
        endfunction

        function bit is_marker(logic [7:0] b);
            return b == start_val || b == escape_val;
        endfunction

        function void push(logic [7:0] b, logic e, logic o);
            frame_bytes.push_back('{data: b, ends: e, ovf: o});
        endfunction

        // marker values go out as escape plus the value flipped by 0x20
        function void push_stuffed(logic [7:0] b);
            if (is_marker(b))
            begin
                push(escape_val, 1'b0, 1'b0);
                push(b ^ StuffXor, 1'b0, 1'b0);
                raw_cnt = raw_cnt + 17'd2;
            end
            else
            begin
                push(b, 1'b0, 1'b0);
                raw_cnt = raw_cnt + 17'd1;
            end
        endfunction

        function void abort_frame(bit last);
            push(8'h00, 1'b1, 1'b1);
            if (last)
            begin
                pkt_open = 1'b0;
                dropping = 1'b0;
            end
            else
            begin
                dropping = 1'b1;
            end
        endfunction

        // predict the output of one accepted input word; 1 if the word was not ignored
        function bit note_word(logic [7:0] b, logic first, logic last, logic [15:0] len);
            logic [16:0] limit;
            limit = {1'b0, max_len};

            // header: start byte and escaped length, or an early abort
            if (first)
            begin
                pkt_open    = 1'b1;
                dropping    = 1'b0;
                sum         = 8'd0;
                raw_cnt     = 17'd0;
                empty_frame = (len == 16'd0);
                if ({1'b0, len} + FrameOverhead > limit)
                begin
                    abort_frame(last);
                    return 1'b1;
                end
                push(start_val, 1'b0, 1'b0);
                raw_cnt = 17'd1;
                push_stuffed(len[15:8]);
                push_stuffed(len[7:0]);
            end
            else if (!pkt_open || dropping)
            begin
                if (last)
                begin
                    pkt_open = 1'b0;
                    dropping = 1'b0;
                end
                return 1'b0;
            end

            // payload byte, checked against the limit before it goes out
            if (!empty_frame)
            begin
                if (raw_cnt > limit)
                begin
                    abort_frame(last);
                    return 1'b1;
                end
                if (is_marker(b) && raw_cnt + 17'd1 > limit)
                begin
                    abort_frame(last);
                    return 1'b1;
                end
                sum = sum + b;
                push_stuffed(b);
            end

            // checksum closes the frame
            if (last)
            begin
                if (raw_cnt > limit)
                begin
                    abort_frame(last);
                    return 1'b1;
                end
                push(SumComplement - sum, 1'b1, 1'b0);
                pkt_open = 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_word(logic [7:0] b, logic e, logic o);
            frame_word_t want;
            if (frame_bytes.size() == 0)
            begin
                $error("unexpected output word: frame_byte %h frame_end %b overflow %b",
                       b, e, o);
                errors++;
                return;
            end
            want = frame_bytes.pop_front();
            words_seen++;
            if (b !== want.data)
            begin
                $error("frame_byte: expected %h, actual %h", want.data, b);
                errors++;
            end
            if (e !== want.ends)
            begin
                $error("frame_end: expected %b, actual %b", want.ends, e);
                errors++;
            end
            if (o !== want.ovf)
            begin
                $error("overflow: expected %b, actual %b", want.ovf, o);
                errors++;
            end
            if (want.ovf)
                frames_aborted++;
            else if (want.ends)
                frames_closed++;
        endfunction

        function int pending();
            return frame_bytes.size();
        endfunction

    endclass

endpackage

FILE: tb/sv/escaped_frame_encoder_tb.sv
// self-checking testbench for the escaped frame encoder
`timescale 1ns / 1ps

module escaped_frame_encoder_tb;

    localparam int LongHold    = 300;
    localparam int DrainCycles = 8;
    localparam int DrainGuard  = 20000;

    logic                        clk             = 1'b0;
    logic                        rst_n           = 1'b0;
    logic                        psel            = 1'b0;
    logic                        penable         = 1'b0;
    logic                        pwrite          = 1'b0;
    logic [efe_pkg::AddrW-1:0]   paddr           = '0;
    logic [31:0]                 pwdata          = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        in_valid        = 1'b0;
    logic                        in_stall;
    logic [7:0]                  payload_byte    = '0;
    logic                        first_of_packet = 1'b0;
    logic                        last_of_packet  = 1'b0;
    logic [15:0]                 frame_length    = '0;
    logic                        out_valid;
    logic                        out_stall       = 1'b0;
    logic [7:0]                  frame_byte;
    logic                        frame_end;
    logic                        overflow;

    bit tx_idle    = 1'b1;
    bit rx_idle    = 1'b1;
    bit hold_req   = 1'b0;
    int live_words = 0;
    int sent_words = 0;
    int phases     = 0;

    efe_tb_pkg::frame_checker frames = new();

    escaped_frame_encoder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .payload_byte    (payload_byte),
        .first_of_packet (first_of_packet),
        .last_of_packet  (last_of_packet),
        .frame_length    (frame_length),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .frame_byte      (frame_byte),
        .frame_end       (frame_end),
        .overflow        (overflow)
    );

    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // receive side: check each accepted word, stall in bursts or one long hold
    initial
    begin : rx_side
        int burst;
        int hold;
        burst = 0;
        hold  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                frames.check_word(frame_byte, frame_end, overflow);
            if (hold_req)
            begin
                hold     = LongHold;
                hold_req = 1'b0;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (rx_idle && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 12) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // offer one input word, with an optional gap ahead of it
    task automatic send_word(input logic [7:0] b, input logic first, input logic last,
                             input logic [15:0] len);
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        payload_byte    <= b;
        first_of_packet <= first;
        last_of_packet  <= last;
        frame_length    <= len;
        do @(posedge clk); while (in_stall);
        sent_words++;
        if (frames.note_word(b, first, last, len))
            live_words++;
    endtask

    // stop sending and wait for every predicted word to come out
    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (frames.pending() != 0 && guard < DrainGuard)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DrainCycles) @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle
    task automatic write_reg(input efe_pkg::reg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        frames.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] s, input logic [7:0] e, input logic [15:0] m);
        drain();
        write_reg(efe_pkg::REG_START, {24'd0, s});
        write_reg(efe_pkg::REG_ESCAPE, {24'd0, e});
        write_reg(efe_pkg::REG_MAXLEN, {16'd0, m});
        phases++;
    endtask

    // payload bytes lean toward the marker values
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0, 1:    return frames.start_val;
            2, 3:    return frames.escape_val;
            default: return 8'($urandom);
        endcase
    endfunction

    // well-formed packet, mostly short, sometimes with a wrong item count
    task automatic send_packet();
        int len_pick;
        int n_items;
        logic [15:0] len;
        len_pick = $urandom_range(0, 19);
        if (len_pick < 3)
            len = 16'd0;
        else if (len_pick < 17)
            len = 16'($urandom_range(1, 10));
        else if (len_pick < 19)
            len = 16'($urandom_range(11, 40));
        else
            len = 16'($urandom);
        if (len == 16'd0)
            n_items = $urandom_range(1, 3);
        else if (len > 16'd40)
            n_items = $urandom_range(1, 6);
        else if ($urandom_range(0, 9) == 0)
            n_items = $urandom_range(1, int'(len) + 2);
        else
            n_items = int'(len);
        for (int i = 0; i < n_items; i++)
            send_word(pick_byte(), i == 0, i == n_items - 1, (i == 0) ? len : 16'($urandom));
    endtask

    // stray words, packets cut short, fully random words
    task automatic send_noise();
        int n_items;
        case ($urandom_range(0, 2))
            0: send_word(8'($urandom), 1'b0, 1'($urandom), 16'($urandom));
            1:
            begin
                n_items = $urandom_range(1, 4);
                for (int i = 0; i < n_items; i++)
                    send_word(pick_byte(), i == 0, 1'b0, 16'($urandom_range(0, 12)));
            end
            default: send_word(8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
        endcase
    endtask

    // keep offering packets and noise until the given number of words went in
    task automatic run_random(input int target);
        int base;
        base = sent_words;
        while (sent_words - base < target)
        begin
            if ($urandom_range(0, 6) == 0)
                send_noise();
            else
                send_packet();
        end
    endtask

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // default registers: zero length, escapes in length and payload
        send_word(8'hAB, 1'b1, 1'b1, 16'd0);
        send_word(8'h12, 1'b1, 1'b0, 16'd0);
        send_word(8'h34, 1'b0, 1'b1, 16'hFFFF);
        send_word(8'h00, 1'b1, 1'b0, 16'h007E);
        send_word(8'h7E, 1'b0, 1'b0, 16'd0);
        send_word(8'h7D, 1'b0, 1'b1, 16'd0);
        send_word(8'hFF, 1'b1, 1'b1, 16'd1);
        // words with no open packet
        send_word(8'h55, 1'b0, 1'b0, 16'd5);
        send_word(8'h66, 1'b0, 1'b1, 16'd5);
        // header too long, rest of packet dropped
        send_word(8'h01, 1'b1, 1'b0, 16'd252);
        send_word(8'h02, 1'b0, 1'b0, 16'd0);
        send_word(8'h03, 1'b0, 1'b1, 16'd0);
        // new first word inside an open packet
        send_word(8'h10, 1'b1, 1'b0, 16'd2);
        send_word(8'h20, 1'b1, 1'b0, 16'd2);
        send_word(8'h30, 1'b0, 1'b1, 16'd0);
        send_word(8'hFF, 1'b1, 1'b1, 16'hFFFF);

        // tight limit: escaped pair that would end past it
        set_config(8'h00, 8'hFF, 16'd12);
        send_word(8'h00, 1'b1, 1'b0, 16'd7);
        send_word(8'hFF, 1'b0, 1'b0, 16'd0);
        send_word(8'h01, 1'b0, 1'b0, 16'd0);
        send_word(8'h02, 1'b0, 1'b0, 16'd0);
        send_word(8'h03, 1'b0, 1'b0, 16'd0);
        send_word(8'h04, 1'b0, 1'b0, 16'd0);
        send_word(8'hFF, 1'b0, 1'b0, 16'd0);
        send_word(8'h05, 1'b0, 1'b1, 16'd0);
        send_word(8'h09, 1'b1, 1'b1, 16'd0);

        // widest limit, with one long receiver hold
        set_config(8'h7E, 8'h7D, 16'hFFFF);
        hold_req = 1'b1;
        run_random(55);

        set_config(8'hFF, 8'h00, 16'd0);
        run_random(30);

        set_config(8'($urandom), 8'($urandom), 16'($urandom_range(5, 60)));
        run_random(50);

        set_config(8'h00, 8'hFF, 16'd12);
        run_random(35);

        set_config(8'($urandom), 8'($urandom), 16'($urandom_range(20, 300)));
        run_random(50);

        // closing stretch at full rate on both sides
        set_config(8'h7E, 8'h7D, 16'd256);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_random(35);

        drain();
        if (frames.pending() != 0)
        begin
            $error("%0d predicted output words never arrived", frames.pending());
            frames.errors++;
        end

        $display("run covered %0d input words (%0d not ignored) over %0d register settings",
                 sent_words, live_words, phases + 1);
        $display("%0d output words, %0d frames closed with checksum, %0d aborted at the limit",
                 frames.words_seen, frames.frames_closed, frames.frames_aborted);
        if (frames.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
